[src/improved_noise_3d_top_defines.svh]
// Assertion macros used by the noise block RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IMPROVED_NOISE_3D_TOP_DEFINES_SVH
`define IMPROVED_NOISE_3D_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IN3D_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("in3d assertion failed");

// Next-cycle implication, checked outside reset.
`define IN3D_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("in3d assertion failed");

`endif

[src/in3d_pkg.sv]
// Types, widths, codes and the gradient function of the 3D noise block.
// No dependencies; used by improved_noise_3d_top.
package in3d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CELL_W    = 8;
  localparam int PERM_W    = 8;
  localparam int HASH_W    = 4;
  localparam int SQ_W      = 2 * FRAC_BITS;
  localparam int POLY_W    = FRAC_BITS + 4;
  localparam int FP_W      = FRAC_BITS + POLY_W;
  localparam int FADE_W    = FRAC_BITS + 1;
  localparam int GRAD_W    = FRAC_BITS + 3;
  localparam int DIFF_W    = GRAD_W + 1;
  localparam int PROD_W    = DIFF_W + FADE_W + 1;
  localparam int OUT_W     = 18;
  localparam int OUT_FRAC  = 16;
  localparam int DOWN      = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int UP        = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int SCALE_W   = GRAD_W + UP + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [HASH_W-1:0] H_V_IS_Y = 4'd4;
  localparam logic [HASH_W-1:0] H_U_IS_Y = 4'd8;
  localparam logic [HASH_W-1:0] H_V_X_A  = 4'd12;
  localparam logic [HASH_W-1:0] H_V_X_B  = 4'd14;

  typedef logic [FRAC_BITS-1:0]     frac_t;
  typedef logic [FADE_W-1:0]        fade_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [PERM_W-1:0]        perm_t;
  typedef logic [HASH_W-1:0]        hash_t;

  localparam grad_t ONE_G = grad_t'(ONE);

  // Dot product of one of twelve gradient directions with the corner offset.
  function automatic grad_t corner_dot(hash_t h, grad_t dx, grad_t dy, grad_t dz);
    grad_t u;
    grad_t v;
    u = (h < H_U_IS_Y) ? dx : dy;
    v = (h < H_V_IS_Y) ? dy : ((h == H_V_X_A || h == H_V_X_B) ? dx : dz);
    return grad_t'((h[0] ? -u : u) + (h[1] ? -v : v));
  endfunction

endpackage

[src/improved_noise_3d_top.sv]
// 3D improved gradient noise, pipelined, one point per cycle unless the output stalls.
// Depends on in3d_pkg and improved_noise_3d_top_defines.svh.
//
// Input channel (in_valid / in_stall): cmd selects a load beat, which writes
// entry_value into permutation entry entry_index, or an evaluate beat, which
// carries signed fixed point coord_x, coord_y and coord_z. Output channel
// (out_valid / out_stall) returns one noise_value beat, signed Q2.16 and
// saturated, for each evaluate beat, in input order. Load beats give no
// output. The table must be loaded before evaluation reads it.
// Throughput is one beat per cycle while the pipeline is not frozen. An
// evaluate beat reaches the output through twelve register stages: the input
// register, three stages of table lookups and fade multiplies, one of gradient
// dot products, then a multiply and an add stage for each of the three lerps,
// and the output register. The table is held in seven copies so that each
// lookup stage reads its own copies; a load beat writes each copy as it
// passes that copy's stage, which keeps lookups ordered with loads.
// When out_stall holds a valid output, the whole pipeline freezes and
// in_stall rises in the same cycle. Reset empties the pipeline and the
// output; the table contents are kept and need loading anyway.
`include "improved_noise_3d_top_defines.svh"

module improved_noise_3d_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [17:0] noise_value
);

  localparam int F = in3d_pkg::FRAC_BITS;

  logic adv;

  // Control
  logic        s1_valid, s2_valid, s3_valid;
  logic        s1_cmd, s2_cmd, s3_cmd;
  logic [11:4] ev_pipe;

  // Payload
  in3d_pkg::perm_t s1_idx, s2_idx, s3_idx;
  in3d_pkg::perm_t s1_val, s2_val, s3_val;
  in3d_pkg::perm_t s1_cx, s1_cy, s1_cz, s2_cy, s2_cz, s3_cz;
  in3d_pkg::frac_t s1_f [3];
  in3d_pkg::frac_t s2_f [3];
  in3d_pkg::frac_t s3_f [3];
  in3d_pkg::frac_t s4_f [3];
  logic [in3d_pkg::SQ_W-1:0]   s2_sq [3];
  logic [in3d_pkg::SQ_W-1:0]   s3_cube [3];
  logic [in3d_pkg::POLY_W-1:0] s3_poly [3];
  logic [in3d_pkg::FP_W-1:0]   s4_fprod [3];
  in3d_pkg::perm_t s2_p0, s2_p1;
  in3d_pkg::perm_t s3_pa, s3_pa1, s3_pb, s3_pb1;
  in3d_pkg::hash_t s4_h [8];

  in3d_pkg::grad_t s5_g [8];
  in3d_pkg::fade_t s5_fade [3];
  in3d_pkg::prod_t s6_m [4];
  in3d_pkg::grad_t s6_base [4];
  in3d_pkg::fade_t s6_fy, s6_fz;
  in3d_pkg::grad_t s7_l [4];
  in3d_pkg::fade_t s7_fy, s7_fz;
  in3d_pkg::prod_t s8_m [2];
  in3d_pkg::grad_t s8_base [2];
  in3d_pkg::fade_t s8_fz;
  in3d_pkg::grad_t s9_l [2];
  in3d_pkg::fade_t s9_fz;
  in3d_pkg::prod_t s10_m;
  in3d_pkg::grad_t s10_base;
  in3d_pkg::grad_t s11_r;

  // Table copies: one for the cell lookups, two for the second level,
  // four for the corner hashes.
  in3d_pkg::perm_t ram1 [256];
  in3d_pkg::perm_t ram2 [2][256];
  in3d_pkg::perm_t ram3 [4][256];

  // Combinational helpers
  in3d_pkg::perm_t s2_a, s2_b;
  in3d_pkg::perm_t s3_aa, s3_ab, s3_ba, s3_bb;
  logic [in3d_pkg::FRAC_BITS+3:0] s4_fd [3];
  in3d_pkg::grad_t s4_d [3][2];
  logic signed [in3d_pkg::DIFF_W-1:0] s5_diff [4];
  logic signed [in3d_pkg::DIFF_W-1:0] s7_diff [2];
  logic signed [in3d_pkg::DIFF_W-1:0] s9_diff;
  logic signed [in3d_pkg::SCALE_W-1:0] s11_scaled;
  logic signed [in3d_pkg::SCALE_W-1:0] sat_hi, sat_lo;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      ev_pipe   <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      ev_pipe   <= {ev_pipe[10:4], s3_valid && (s3_cmd == in3d_pkg::CMD_EVAL)};
      out_valid <= ev_pipe[11];
    end
  end

  // Lookup and fade stages
  always_comb begin
    s2_a  = s2_p0 + s2_cy;
    s2_b  = s2_p1 + s2_cy;
    s3_aa = s3_pa + s3_cz;
    s3_ab = s3_pa1 + s3_cz;
    s3_ba = s3_pb + s3_cz;
    s3_bb = s3_pb1 + s3_cz;
    for (int k = 0; k < 3; k++) begin
      s4_fd[k]   = s4_fprod[k][in3d_pkg::FP_W-1:F];
      s4_d[k][0] = in3d_pkg::grad_t'(s4_f[k]);
      s4_d[k][1] = in3d_pkg::grad_t'(in3d_pkg::grad_t'(s4_f[k]) - in3d_pkg::ONE_G);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd <= cmd;
      s1_idx <= entry_index;
      s1_val <= entry_value;
      s1_cx  <= coord_x[F+in3d_pkg::CELL_W-1:F];
      s1_cy  <= coord_y[F+in3d_pkg::CELL_W-1:F];
      s1_cz  <= coord_z[F+in3d_pkg::CELL_W-1:F];
      s1_f[0] <= coord_x[F-1:0];
      s1_f[1] <= coord_y[F-1:0];
      s1_f[2] <= coord_z[F-1:0];

      s2_cmd <= s1_cmd;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_cy  <= s1_cy;
      s2_cz  <= s1_cz;
      s3_cmd <= s2_cmd;
      s3_idx <= s2_idx;
      s3_val <= s2_val;
      s3_cz  <= s2_cz;

      for (int k = 0; k < 3; k++) begin
        s2_f[k]  <= s1_f[k];
        s3_f[k]  <= s2_f[k];
        s4_f[k]  <= s3_f[k];
        s2_sq[k] <= in3d_pkg::SQ_W'(s1_f[k]) * in3d_pkg::SQ_W'(s1_f[k]);
        s3_cube[k] <= in3d_pkg::SQ_W'(s2_sq[k][in3d_pkg::SQ_W-1:F]) *
                      in3d_pkg::SQ_W'(s2_f[k]);
        // 6*t2 + 10 - 15*t stays positive on [0, 1).
        s3_poly[k] <= in3d_pkg::POLY_W'(
          (in3d_pkg::POLY_W+1)'(s2_sq[k][in3d_pkg::SQ_W-1:F]) * (in3d_pkg::POLY_W+1)'(6)
          + (in3d_pkg::POLY_W+1)'(10 * in3d_pkg::ONE)
          - (in3d_pkg::POLY_W+1)'(s2_f[k]) * (in3d_pkg::POLY_W+1)'(15));
        s4_fprod[k] <= in3d_pkg::FP_W'(s3_cube[k][in3d_pkg::SQ_W-1:F]) *
                       in3d_pkg::FP_W'(s3_poly[k]);
      end
    end
  end

  // Each copy is written by a load beat at the stage that reads it.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid && (s1_cmd == in3d_pkg::CMD_LOAD)) begin
        ram1[s1_idx] <= s1_val;
      end
      s2_p0 <= ram1[s1_cx];
      s2_p1 <= ram1[s1_cx + 8'd1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_valid && (s2_cmd == in3d_pkg::CMD_LOAD)) begin
        for (int c = 0; c < 2; c++) begin
          ram2[c][s2_idx] <= s2_val;
        end
      end
      s3_pa  <= ram2[0][s2_a];
      s3_pa1 <= ram2[0][s2_a + 8'd1];
      s3_pb  <= ram2[1][s2_b];
      s3_pb1 <= ram2[1][s2_b + 8'd1];
    end
  end

  // Corner i uses the far x face when bit 0 is set, far y for bit 1, far z
  // for bit 2.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_valid && (s3_cmd == in3d_pkg::CMD_LOAD)) begin
        for (int c = 0; c < 4; c++) begin
          ram3[c][s3_idx] <= s3_val;
        end
      end
      s4_h[0] <= ram3[0][s3_aa][in3d_pkg::HASH_W-1:0];
      s4_h[4] <= ram3[0][s3_aa + 8'd1][in3d_pkg::HASH_W-1:0];
      s4_h[2] <= ram3[1][s3_ab][in3d_pkg::HASH_W-1:0];
      s4_h[6] <= ram3[1][s3_ab + 8'd1][in3d_pkg::HASH_W-1:0];
      s4_h[1] <= ram3[2][s3_ba][in3d_pkg::HASH_W-1:0];
      s4_h[5] <= ram3[2][s3_ba + 8'd1][in3d_pkg::HASH_W-1:0];
      s4_h[3] <= ram3[3][s3_bb][in3d_pkg::HASH_W-1:0];
      s4_h[7] <= ram3[3][s3_bb + 8'd1][in3d_pkg::HASH_W-1:0];
    end
  end

  // Gradients, then the three lerp levels
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s5_diff[i] = in3d_pkg::DIFF_W'(s5_g[2*i+1]) - in3d_pkg::DIFF_W'(s5_g[2*i]);
    end
    for (int i = 0; i < 2; i++) begin
      s7_diff[i] = in3d_pkg::DIFF_W'(s7_l[2*i+1]) - in3d_pkg::DIFF_W'(s7_l[2*i]);
    end
    s9_diff = in3d_pkg::DIFF_W'(s9_l[1]) - in3d_pkg::DIFF_W'(s9_l[0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_fade[k] <= (s4_fd[k] > (in3d_pkg::FRAC_BITS+4)'(in3d_pkg::ONE)) ?
                      in3d_pkg::fade_t'(in3d_pkg::ONE) : s4_fd[k][in3d_pkg::FADE_W-1:0];
      end
      for (int i = 0; i < 8; i++) begin
        s5_g[i] <= in3d_pkg::corner_dot(s4_h[i], s4_d[0][i%2], s4_d[1][(i/2)%2],
                                        s4_d[2][i/4]);
      end

      for (int i = 0; i < 4; i++) begin
        s6_m[i]    <= in3d_pkg::PROD_W'(s5_diff[i]) *
                      in3d_pkg::PROD_W'($signed({1'b0, s5_fade[0]}));
        s6_base[i] <= s5_g[2*i];
      end
      s6_fy <= s5_fade[1];
      s6_fz <= s5_fade[2];

      for (int i = 0; i < 4; i++) begin
        s7_l[i] <= s6_base[i] + in3d_pkg::grad_t'(s6_m[i] >>> F);
      end
      s7_fy <= s6_fy;
      s7_fz <= s6_fz;

      for (int i = 0; i < 2; i++) begin
        s8_m[i]    <= in3d_pkg::PROD_W'(s7_diff[i]) *
                      in3d_pkg::PROD_W'($signed({1'b0, s7_fy}));
        s8_base[i] <= s7_l[2*i];
      end
      s8_fz <= s7_fz;

      for (int i = 0; i < 2; i++) begin
        s9_l[i] <= s8_base[i] + in3d_pkg::grad_t'(s8_m[i] >>> F);
      end
      s9_fz <= s8_fz;

      s10_m    <= in3d_pkg::PROD_W'(s9_diff) * in3d_pkg::PROD_W'($signed({1'b0, s9_fz}));
      s10_base <= s9_l[0];

      s11_r <= s10_base + in3d_pkg::grad_t'(s10_m >>> F);
    end
  end

  // Rescale to 16 fraction bits and saturate into Q2.16.
  always_comb begin
    sat_hi     = in3d_pkg::SCALE_W'((1 << (in3d_pkg::OUT_W - 1)) - 1);
    sat_lo     = -in3d_pkg::SCALE_W'(1 << (in3d_pkg::OUT_W - 1));
    s11_scaled = (in3d_pkg::SCALE_W'(s11_r) >>> in3d_pkg::DOWN) <<< in3d_pkg::UP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s11_scaled > sat_hi) begin
        noise_value <= sat_hi[in3d_pkg::OUT_W-1:0];
      end else if (s11_scaled < sat_lo) begin
        noise_value <= sat_lo[in3d_pkg::OUT_W-1:0];
      end else begin
        noise_value <= s11_scaled[in3d_pkg::OUT_W-1:0];
      end
    end
  end

  `IN3D_ASSERT_NXT(a_freeze, clk, rst, out_valid && out_stall,
    $stable(ev_pipe) && $stable(s1_valid) && $stable(s3_valid))
  `IN3D_ASSERT_NXT(a_out_follows, clk, rst, !out_valid || !out_stall,
    out_valid == $past(ev_pipe[11]))
  `IN3D_ASSERT_NXT(a_eval_enters, clk, rst,
    adv && s3_valid && (s3_cmd == in3d_pkg::CMD_EVAL), ev_pipe[4])

endmodule
